/* src/lpr_pkg.sv */
// ----------------------------------------------------------------------------
// lpr_pkg
// Types and constants shared by the line pixel rasteriser modules.
// ----------------------------------------------------------------------------
package lpr_pkg;

  localparam int CoordW = 6;
  localparam int RowW   = 7;
  localparam int DimW   = 7;
  localparam int ColorW = 8;
  localparam int AddrW  = 12;
  localparam int ErrW   = 13;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 8;

  localparam logic [DimW-1:0]   WidthReset  = 7'd64;
  localparam logic [DimW-1:0]   HeightReset = 7'd64;
  localparam logic [ColorW-1:0] SkipReset   = 8'd255;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_SKIP_COLOR   = 2'd2
  } lpr_cfg_idx_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EMIT = 1'b1
  } lpr_state_e;

  typedef struct packed {
    logic [CoordW-1:0] x_start;
    logic [CoordW-1:0] y_start;
    logic [CoordW-1:0] x_end;
    logic [CoordW-1:0] y_end;
    logic [ColorW-1:0] color;
  } lpr_cmd_t;

  typedef struct packed {
    logic [CoordW-1:0] pix_x;
    logic [RowW-1:0]   pix_y;
    logic [AddrW-1:0]  pix_address;
    logic [ColorW-1:0] pix_color;
    logic              out_of_range;
    logic              last;
  } lpr_pix_t;

  typedef struct packed {
    logic load;
    logic advance;
  } lpr_step_ctrl_t;

  typedef struct packed {
    logic [CoordW-1:0] cur_x;
    logic [RowW-1:0]   cur_y;
    logic [ColorW-1:0] color;
    logic              last;
  } lpr_step_stat_t;

endpackage

/* src/lpr_step_unit.sv */
// ----------------------------------------------------------------------------
// lpr_step_unit
// Error-term stepper: holds the line state and advances one pixel per step.
// ----------------------------------------------------------------------------
module lpr_step_unit #(
  parameter int MAX_DIM = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lpr_pkg::lpr_cmd_t      cmd_i,
  input  lpr_pkg::lpr_step_ctrl_t ctrl_i,
  output lpr_pkg::lpr_step_stat_t stat_o
);

  localparam int CntW = $clog2(MAX_DIM);
  localparam int CapW = 9;
  localparam int ErrW = lpr_pkg::ErrW;
  localparam int DW   = lpr_pkg::CoordW + 1;

  logic [lpr_pkg::CoordW-1:0] cur_x_q, cur_x_d;
  logic [lpr_pkg::RowW-1:0]   cur_y_q, cur_y_d;
  logic signed [ErrW-1:0]     err_q, err_d;
  logic signed [DW-1:0]       dx_q, dx_d;
  logic signed [DW-1:0]       dy_q, dy_d;
  logic [CntW-1:0]            rem_q, rem_d;
  logic [lpr_pkg::ColorW-1:0] color_q, color_d;

  logic signed [DW-1:0]   dx_new;
  logic signed [DW-1:0]   dy_new;
  logic signed [DW-1:0]   dx_half;
  logic [CapW-1:0]        dx_ext;
  logic [CapW-1:0]        steps_ext;
  logic signed [ErrW-1:0] err_sum;
  logic signed [ErrW-1:0] err_diff;

  assign dx_new = DW'({1'b0, cmd_i.x_end}) - DW'({1'b0, cmd_i.x_start});
  assign dy_new = DW'({1'b0, cmd_i.y_end}) - DW'({1'b0, cmd_i.y_start});
  assign dx_half = (dx_new + $signed({{(DW-1){1'b0}}, dx_new[DW-1]})) >>> 1;
  assign dx_ext  = CapW'({1'b0, dx_new[DW-2:0]});

  always_comb begin
    if (dx_new[DW-1] || (dx_new == '0)) begin
      steps_ext = '0;
    end else if (dx_ext > CapW'(MAX_DIM - 1)) begin
      steps_ext = CapW'(MAX_DIM - 1);
    end else begin
      steps_ext = dx_ext;
    end
  end

  // shared add then compare against dx
  assign err_sum  = err_q + ErrW'(dy_q);
  assign err_diff = err_sum - ErrW'(dx_q);

  always_comb begin
    cur_x_d = cur_x_q;
    cur_y_d = cur_y_q;
    err_d   = err_q;
    dx_d    = dx_q;
    dy_d    = dy_q;
    rem_d   = rem_q;
    color_d = color_q;
    if (ctrl_i.load) begin
      cur_x_d = cmd_i.x_start;
      cur_y_d = lpr_pkg::RowW'(cmd_i.y_start);
      err_d   = ErrW'(dx_half);
      dx_d    = dx_new;
      dy_d    = dy_new;
      rem_d   = steps_ext[CntW-1:0];
      color_d = cmd_i.color;
    end else if (ctrl_i.advance) begin
      if (!err_diff[ErrW-1]) begin
        err_d   = err_diff;
        cur_y_d = cur_y_q + 1'b1;
      end else begin
        err_d = err_sum;
      end
      cur_x_d = cur_x_q + 1'b1;
      rem_d   = rem_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q   <= '0;
      cur_x_q <= '0;
      cur_y_q <= '0;
      err_q   <= '0;
      dx_q    <= '0;
      dy_q    <= '0;
      color_q <= '0;
    end else begin
      rem_q   <= rem_d;
      cur_x_q <= cur_x_d;
      cur_y_q <= cur_y_d;
      err_q   <= err_d;
      dx_q    <= dx_d;
      dy_q    <= dy_d;
      color_q <= color_d;
    end
  end

  assign stat_o.cur_x = cur_x_q;
  assign stat_o.cur_y = cur_y_q;
  assign stat_o.color = color_q;
  assign stat_o.last  = (rem_q == '0);

endmodule

/* src/lpr_pixel_fmt.sv */
// ----------------------------------------------------------------------------
// lpr_pixel_fmt
// Forms the linear address and range flag of the current pixel.
// ----------------------------------------------------------------------------
module lpr_pixel_fmt (
  input  lpr_pkg::lpr_step_stat_t        stat_i,
  input  logic [lpr_pkg::DimW-1:0]       image_width_i,
  input  logic [lpr_pkg::DimW-1:0]       image_height_i,
  output lpr_pkg::lpr_pix_t              pix_o
);

  localparam int ProdW = 2 * lpr_pkg::DimW;

  logic [ProdW-1:0] prod;
  logic [ProdW-1:0] lin;
  logic             oor;

  assign prod = ProdW'(stat_i.cur_y) * ProdW'(image_width_i);
  assign lin  = prod + ProdW'(stat_i.cur_x);
  assign oor  = (lpr_pkg::DimW'(stat_i.cur_x) >= image_width_i) ||
                (stat_i.cur_y >= image_height_i);

  assign pix_o.pix_x        = stat_i.cur_x;
  assign pix_o.pix_y        = stat_i.cur_y;
  assign pix_o.pix_address  = oor ? '0 : lin[lpr_pkg::AddrW-1:0];
  assign pix_o.pix_color    = stat_i.color;
  assign pix_o.out_of_range = oor;
  assign pix_o.last         = stat_i.last;

endmodule

/* src/line_pixel_rasterizer_unit.sv */
// ----------------------------------------------------------------------------
// line_pixel_rasterizer_unit
// First-octant line rasteriser: one line command in, a run of pixels out.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : one line command per transaction (start, end, colour).
//   out channel : one pixel per transaction, in rising x, last set on the
//                 final pixel of the line.
//   cfg channel : image width, image height and skip colour; always ready,
//                 to be written only while the unit is idle.
// Timing:
//   a command with dx = x_end - x_start gives min(max(dx,0), MAX_DIM-1) + 1
//   pixels; the command is loaded into the stepper registers, then each pixel
//   enters the output register, one per cycle while the output is taken.
//   The rate is set by the error-term stepper, one step per cycle while the
//   output is free. A command with the skip colour, or an empty image, gives
//   no pixels and the unit stays ready.
// Reset: the unit is idle with no pixel pending; registers take 64, 64, 255.
// Stall: the output register holds a pixel until taken and the stepper waits;
//   a new command is taken only once the last pixel sits in the output stage.
// ----------------------------------------------------------------------------
module line_pixel_rasterizer_unit #(
  parameter int MAX_DIM = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  lpr_pkg::lpr_cmd_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output lpr_pkg::lpr_pix_t               out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [lpr_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [lpr_pkg::CfgDataW-1:0]    cfg_data_i
);

  lpr_pkg::lpr_state_e     state_q, state_d;
  lpr_pkg::lpr_step_ctrl_t step_ctrl;
  lpr_pkg::lpr_step_stat_t step_stat;
  lpr_pkg::lpr_pix_t       pix_next;
  lpr_pkg::lpr_pix_t       out_data_q;

  logic [lpr_pkg::DimW-1:0]   image_width_q;
  logic [lpr_pkg::DimW-1:0]   image_height_q;
  logic [lpr_pkg::ColorW-1:0] skip_color_q;
  logic                       out_valid_q, out_valid_d;
  logic                       cmd_accept;
  logic                       cmd_draw;
  logic                       out_free;
  logic                       emit;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= lpr_pkg::WidthReset;
      image_height_q <= lpr_pkg::HeightReset;
      skip_color_q   <= lpr_pkg::SkipReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        lpr_pkg::CFG_IMAGE_WIDTH: begin
          image_width_q <= cfg_data_i[lpr_pkg::DimW-1:0];
        end
        lpr_pkg::CFG_IMAGE_HEIGHT: begin
          image_height_q <= cfg_data_i[lpr_pkg::DimW-1:0];
        end
        lpr_pkg::CFG_SKIP_COLOR: begin
          skip_color_q <= cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  assign in_ready_o = (state_q == lpr_pkg::ST_IDLE);
  assign cmd_accept = in_valid_i && in_ready_o;
  assign cmd_draw   = cmd_accept && (in_data_i.color != skip_color_q) &&
                      (image_width_q != '0) && (image_height_q != '0);
  assign out_free   = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lpr_pkg::ST_IDLE: begin
        if (cmd_draw) begin
          state_d = lpr_pkg::ST_EMIT;
        end
      end
      lpr_pkg::ST_EMIT: begin
        if (out_free && step_stat.last) begin
          state_d = lpr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lpr_pkg::ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    emit              = 1'b0;
    step_ctrl.load    = 1'b0;
    step_ctrl.advance = 1'b0;
    case (state_q)
      lpr_pkg::ST_IDLE: begin
        step_ctrl.load = cmd_draw;
      end
      lpr_pkg::ST_EMIT: begin
        emit              = out_free;
        step_ctrl.advance = out_free && !step_stat.last;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lpr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  lpr_step_unit #(
    .MAX_DIM (MAX_DIM)
  ) u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (in_data_i),
    .ctrl_i (step_ctrl),
    .stat_o (step_stat)
  );

  lpr_pixel_fmt u_fmt (
    .stat_i         (step_stat),
    .image_width_i  (image_width_q),
    .image_height_i (image_height_q),
    .pix_o          (pix_next)
  );

  // output stage
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q <= pix_next;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_more_after_non_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last |-> state_q == lpr_pkg::ST_EMIT)
    else $error("non-last pixel taken with no line in progress");

  a_skip_no_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_accept && (in_data_i.color == skip_color_q) |=> state_q == lpr_pkg::ST_IDLE)
    else $error("skip colour command started a line");

  a_oor_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.out_of_range |-> out_data_o.pix_address == '0)
    else $error("out of range pixel with non-zero address");

endmodule
